### src/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg - shared types and constants of the first-fit heap allocator
// Segment and rebuild records, sequencer states, status, kind and register codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int unsigned MAX_SEGMENTS_DEF = 64;
	localparam logic [31:0] HEADER_BYTES     = 32'd16;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NOFIT    = 2'd1;
	localparam logic [1:0] STS_NOTFOUND = 2'd2;

	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_BYTES = 1'b1;

	typedef struct packed {
		logic [31:0] hdr;
		logic [31:0] size;
		logic        used;
	} seg_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] base;
		logic [31:0] bytes;
	} rebuild_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_CHK,
		ST_SPL_SH,
		ST_SPL_NEW,
		ST_SPL_CUR,
		ST_F_CHK,
		ST_F_NCHK,
		ST_RM_SH,
		ST_F_WCUR,
		ST_F_PCHK
	} state_t;

endpackage

### src/ffha_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_req_if - request channel
// Valid/ready channel carrying allocate and free requests.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] alloc_size;
	logic [31:0] free_addr;

	modport source (output valid, kind, alloc_size, free_addr, input ready);
	modport sink   (input valid, kind, alloc_size, free_addr, output ready);
endinterface

### src/ffha_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_rsp_if - response channel
// Valid/ready channel carrying payload address and status.
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] payload_addr;
	logic [1:0]  status;

	modport source (output valid, payload_addr, status, input ready);
	modport sink   (input valid, payload_addr, status, output ready);
endinterface

### src/ffha_seg_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_seg_mem - segment table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_seg_mem
	import ffha_pkg::*;
#(
	parameter int unsigned DEPTH = MAX_SEGMENTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  seg_t                     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output seg_t                     rdata_q
);

	seg_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

### src/ffha_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_engine - allocator sequencer
// Walks the segment table one entry a cycle, splits, merges and shifts.
// ----------------------------------------------------------------------------
module ffha_engine
	import ffha_pkg::*;
#(
	parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rebuild_t    rebuild,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp
);

	localparam int unsigned IW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

	state_t        state_q, state_d, ret_q, ret_d;
	logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, j_q, j_d;
	seg_t          cur_q, cur_d;
	logic [31:0]   size_q, addr_q;
	logic          res_valid_q;
	logic [31:0]   res_addr_q;
	logic [1:0]    res_sts_q;
	logic          fin;
	logic [31:0]   fin_addr;
	logic [1:0]    fin_sts;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	seg_t          wdata, rdata;
	logic [CW:0]   idx_p1, idx_p2, j_p2, cnt_w;
	logic          acc;

	ffha_seg_mem #(.DEPTH(MAX_SEGMENTS)) u_mem (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	assign req.ready        = (state_q == ST_IDLE) && !res_valid_q;
	assign acc              = req.valid && req.ready;
	assign rsp.valid        = res_valid_q;
	assign rsp.payload_addr = res_addr_q;
	assign rsp.status       = res_sts_q;

	assign idx_p1 = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_p2 = {1'b0, idx_q} + (CW+1)'(2);
	assign j_p2   = {1'b0, j_q} + (CW+1)'(2);
	assign cnt_w  = {1'b0, cnt_q};

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		j_d      = j_q;
		cur_d    = cur_q;
		fin      = 1'b0;
		fin_addr = '0;
		fin_sts  = STS_OK;
		we       = 1'b0;
		waddr    = idx_q[IW-1:0];
		wdata    = cur_q;
		raddr    = '0;
		case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (rebuild.valid) begin
					we    = 1'b1;
					waddr = '0;
					wdata = '{hdr: rebuild.base, size: rebuild.bytes - HEADER_BYTES,
						used: 1'b0};
					cnt_d = (rebuild.bytes >= HEADER_BYTES) ? CW'(1) : '0;
				end else if (acc) begin
					if (cnt_q == '0) begin
						fin     = 1'b1;
						fin_sts = (req.kind == KIND_ALLOC) ? STS_NOFIT : STS_NOTFOUND;
					end else begin
						state_d = (req.kind == KIND_ALLOC) ? ST_A_CHK : ST_F_CHK;
					end
				end
			end
			ST_A_CHK: begin
				if (!rdata.used && rdata.size > size_q) begin
					cur_d = rdata;
					if ({1'b0, rdata.size} >= {1'b0, size_q} + {1'b0, HEADER_BYTES} + 33'd1
							&& cnt_w < (CW+1)'(MAX_SEGMENTS)) begin
						j_d = cnt_q;
						if (cnt_w > idx_p1) begin
							raddr   = IW'(cnt_q - CW'(1));
							state_d = ST_SPL_SH;
						end else begin
							state_d = ST_SPL_NEW;
						end
					end else begin
						we       = 1'b1;
						wdata    = '{hdr: rdata.hdr, size: rdata.size, used: 1'b1};
						fin      = 1'b1;
						fin_addr = rdata.hdr + HEADER_BYTES;
						state_d  = ST_IDLE;
					end
				end else if (idx_p1 == cnt_w) begin
					fin     = 1'b1;
					fin_sts = STS_NOFIT;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_p1[CW-1:0];
					raddr = idx_p1[IW-1:0];
				end
			end
			ST_SPL_SH: begin
				// move entry j-1 up to j
				we    = 1'b1;
				waddr = j_q[IW-1:0];
				wdata = rdata;
				j_d   = j_q - CW'(1);
				if ({1'b0, j_d} > idx_p1) begin
					raddr = IW'(j_q - CW'(2));
				end else begin
					state_d = ST_SPL_NEW;
				end
			end
			ST_SPL_NEW: begin
				we      = 1'b1;
				waddr   = idx_p1[IW-1:0];
				wdata   = '{hdr: cur_q.hdr + HEADER_BYTES + size_q,
					size: cur_q.size - size_q - HEADER_BYTES, used: 1'b0};
				state_d = ST_SPL_CUR;
			end
			ST_SPL_CUR: begin
				we       = 1'b1;
				wdata    = '{hdr: cur_q.hdr, size: size_q, used: 1'b1};
				cnt_d    = cnt_q + CW'(1);
				fin      = 1'b1;
				fin_addr = cur_q.hdr + HEADER_BYTES;
				state_d  = ST_IDLE;
			end
			ST_F_CHK: begin
				if (rdata.hdr + HEADER_BYTES == addr_q) begin
					cur_d = '{hdr: rdata.hdr, size: rdata.size, used: 1'b0};
					if (idx_p1 < cnt_w) begin
						raddr   = idx_p1[IW-1:0];
						state_d = ST_F_NCHK;
					end else begin
						state_d = ST_F_WCUR;
					end
				end else if (idx_p1 == cnt_w) begin
					fin     = 1'b1;
					fin_sts = STS_NOTFOUND;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_p1[CW-1:0];
					raddr = idx_p1[IW-1:0];
				end
			end
			ST_F_NCHK: begin
				if (!rdata.used) begin
					cur_d.size = cur_q.size + rdata.size + HEADER_BYTES;
					j_d        = idx_p1[CW-1:0];
					ret_d      = ST_F_WCUR;
					if (idx_p2 < cnt_w) begin
						raddr   = idx_p2[IW-1:0];
						state_d = ST_RM_SH;
					end else begin
						cnt_d   = cnt_q - CW'(1);
						state_d = ST_F_WCUR;
					end
				end else begin
					state_d = ST_F_WCUR;
				end
			end
			ST_RM_SH: begin
				// move entry j+1 down to j
				we    = 1'b1;
				waddr = j_q[IW-1:0];
				wdata = rdata;
				j_d   = j_q + CW'(1);
				if (j_p2 < cnt_w) begin
					raddr = j_p2[IW-1:0];
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = ret_q;
					if (ret_q == ST_IDLE) begin
						fin = 1'b1;
					end
				end
			end
			ST_F_WCUR: begin
				we = 1'b1;
				if (idx_q != '0) begin
					raddr   = IW'(idx_q - CW'(1));
					state_d = ST_F_PCHK;
				end else begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_F_PCHK: begin
				if (!rdata.used) begin
					we    = 1'b1;
					waddr = IW'(idx_q - CW'(1));
					wdata = '{hdr: rdata.hdr,
						size: rdata.size + cur_q.size + HEADER_BYTES, used: 1'b0};
					j_d   = idx_q;
					ret_d = ST_IDLE;
					if (idx_p1 < cnt_w) begin
						raddr   = idx_p1[IW-1:0];
						state_d = ST_RM_SH;
					end else begin
						cnt_d   = cnt_q - CW'(1);
						fin     = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			cnt_q   <= cnt_d;
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		j_q   <= j_d;
		cur_q <= cur_d;
		if (acc) begin
			size_q <= req.alloc_size;
			addr_q <= req.free_addr;
		end
		if (fin) begin
			res_addr_q <= fin_addr;
			res_sts_q  <= fin_sts;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SEGMENTS))
		else $error("segment count above table depth");

	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> state_q == ST_IDLE)
		else $error("result pending while sequencer busy");

	a_split_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPL_CUR |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("split did not add a segment");

endmodule

### src/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator - first-fit heap allocator with coalescing
// APB register block plus the table sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: kind (allocate / free), alloc_size, free_addr. One transfer
//    gives exactly one transfer on rsp: payload_addr and status.
//  - APB: heap_base at 0x0, heap_bytes at 0x4. A write rebuilds the table
//    to one free segment (none if heap_bytes < header). Write only when idle.
//  - Sequencing: allocate walks the table one entry a cycle, and a split then
//    shifts the tail up one entry a cycle; free walks likewise, and each
//    merge shifts the tail down one entry a cycle.
//  - One request at a time: req.ready is low while the sequencer works and
//    while a result waits in the output register.
//  - Reset: empty table, both registers zero; no clearing pass needed.
//  - A stalled rsp holds its payload; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] heap_base_q, heap_bytes_q;
	logic        wr;
	rebuild_t    rebuild;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	// byte address bits below the word are ignored
	assign prdata = (paddr[2] == REG_HEAP_BYTES) ? heap_bytes_q : heap_base_q;

	assign rebuild.valid = wr;
	assign rebuild.base  = (paddr[2] == REG_HEAP_BASE)  ? pwdata : heap_base_q;
	assign rebuild.bytes = (paddr[2] == REG_HEAP_BYTES) ? pwdata : heap_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_bytes_q <= '0;
		end else if (wr) begin
			heap_base_q  <= rebuild.base;
			heap_bytes_q <= rebuild.bytes;
		end
	end

	ffha_engine #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.rebuild (rebuild),
		.req     (req),
		.rsp     (rsp)
	);

endmodule
